>>> hdl/event_trace_recorder_macros.svh
`ifndef EVENT_TRACE_RECORDER_MACROS_SVH
`define EVENT_TRACE_RECORDER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define ETR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define ETR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/etr_pkg.sv
package etr_pkg;

	localparam int STORE_BYTES_DEF    = 1024;
	localparam int RECORD_RESERVE_DEF = 6;

	localparam int READ_ADDR_W = 10;
	localparam int BLK_W       = 11;
	localparam int REC_W       = 48;
	localparam int REC_CNT_W   = 3;

	typedef enum logic [2:0] {
		OP_START = 3'd0,
		OP_STOP  = 3'd1,
		OP_CLEAR = 3'd2,
		OP_EVENT = 3'd3,
		OP_DATA  = 3'd4,
		OP_READ  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REC,
		ST_FIN
	} st_t;

	// Event record: byte 0 in bits 7:0, up to six bytes, and how many are used.
	typedef struct packed {
		logic [REC_W-1:0]     bytes;
		logic [REC_CNT_W-1:0] nbytes;
	} rec_t;

endpackage

>>> hdl/etr_rec_fmt.sv
module etr_rec_fmt (
	input  logic [31:0]  timestamp,
	input  logic [31:0]  last_time,
	input  logic [7:0]   label,
	input  logic [5:0]   event_code,
	input  logic         compact,
	output etr_pkg::rec_t rec
);

	logic [31:0] delta;
	logic [1:0]  len;

	always_comb begin
		delta = timestamp - last_time;
		if (delta[31:8] == 24'd0) begin
			len = 2'd0;
		end else if (delta[31:16] == 16'd0) begin
			len = 2'd1;
		end else if (delta[31:24] == 8'd0) begin
			len = 2'd2;
		end else begin
			len = 2'd3;
		end

		if (compact) begin
			rec.bytes  = {delta, len, event_code, label};
			rec.nbytes = etr_pkg::REC_CNT_W'(len) + etr_pkg::REC_CNT_W'(3);
		end else begin
			rec.bytes  = {timestamp, 2'b00, event_code, label};
			rec.nbytes = etr_pkg::REC_CNT_W'(6);
		end
	end

endmodule

>>> hdl/event_trace_recorder.sv
// Byte trace buffer. Each input transaction is one operation (start, stop, clear,
// event, data byte, read byte) and gives exactly one result transaction. Start,
// stop, clear, data byte, read and unknown codes pass from acceptance to the finish
// state, which puts the result into the output register once that register is
// free, and the next transaction is accepted after it leaves the finish state.
// An event that is recorded first writes each record byte (3 to 6 bytes in compact
// mode, 6 in normal mode), one byte write per cycle into the single-port byte store.
// The output register lets the next transaction be accepted while a result waits;
// that transaction completes once the output register is free. The store needs
// no clearing after reset: only bytes below the fill count are ever read.
`include "event_trace_recorder_macros.svh"

module event_trace_recorder #(
	parameter int STORE_BYTES    = etr_pkg::STORE_BYTES_DEF,
	parameter int RECORD_RESERVE = etr_pkg::RECORD_RESERVE_DEF,
	localparam int CW = $clog2(STORE_BYTES + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      cfg_wr_en,
	input  logic                      cfg_wr_data,

	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [2:0]                mode,
	input  logic [31:0]               timestamp,
	input  logic [7:0]                label,
	input  logic [5:0]                event_code,
	input  logic [7:0]                data_byte,
	input  logic                      last_of_block,
	input  logic [etr_pkg::READ_ADDR_W-1:0] read_address,

	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      accepted,
	output logic [7:0]                read_data,
	output logic                      read_valid,
	output logic [CW-1:0]             byte_count,
	output logic                      recording,
	output logic [etr_pkg::BLK_W-1:0] block_written
);

	localparam int AW    = $clog2(STORE_BYTES);
	localparam int XW    = (AW > etr_pkg::READ_ADDR_W) ? AW : etr_pkg::READ_ADDR_W;
	localparam int CMP_W = (CW > etr_pkg::READ_ADDR_W) ? CW : etr_pkg::READ_ADDR_W;
	localparam logic [CW-1:0] EV_LIMIT = CW'(STORE_BYTES - RECORD_RESERVE);
	localparam logic [CW-1:0] FULL     = CW'(STORE_BYTES);

	etr_pkg::st_t state_q, state_d;

	logic                          compact_q;
	logic [CW-1:0]                 fill_q;
	logic [31:0]                   last_time_q;
	logic                          active_q;
	logic [etr_pkg::BLK_W-1:0]     blk_q;
	logic [etr_pkg::REC_W-1:0]     rec_q;
	logic [etr_pkg::REC_CNT_W-1:0] rem_q;
	logic                          res_acc_q;
	logic                          res_rv_q;
	logic [etr_pkg::BLK_W-1:0]     res_blk_q;
	logic                          out_valid_q;

	logic [7:0]    mem [STORE_BYTES];
	logic [7:0]    mem_rd_q;
	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wd;

	logic          take;
	logic          out_free;
	logic          ev_ok;
	logic          db_ok;
	logic          rd_ok;
	logic [XW-1:0] rd_wide;
	etr_pkg::rec_t rec;

	etr_rec_fmt u_rec_fmt (
		.timestamp  (timestamp),
		.last_time  (last_time_q),
		.label      (label),
		.event_code (event_code),
		.compact    (compact_q),
		.rec        (rec)
	);

	always_comb begin
		in_stall = (state_q != etr_pkg::ST_IDLE);
		take     = in_valid && !in_stall;
		out_free = !out_valid_q || !out_stall;
		ev_ok    = active_q && (fill_q < EV_LIMIT);
		db_ok    = active_q && (fill_q < FULL);
		rd_ok    = CMP_W'(read_address) < CMP_W'(fill_q);
		rd_wide  = XW'(read_address);

		state_d  = state_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = fill_q[AW-1:0];
		mem_wd   = rec_q[7:0];

		case (state_q)
			etr_pkg::ST_IDLE: begin
				if (take) begin
					state_d = etr_pkg::ST_FIN;
					case (etr_pkg::op_t'(mode))
						etr_pkg::OP_EVENT: begin
							if (ev_ok) begin
								state_d = etr_pkg::ST_REC;
							end
						end
						etr_pkg::OP_DATA: begin
							mem_we = db_ok;
							mem_wd = data_byte;
						end
						etr_pkg::OP_READ: begin
							mem_re   = 1'b1;
							mem_addr = rd_wide[AW-1:0];
						end
						default: begin
						end
					endcase
				end
			end
			etr_pkg::ST_REC: begin
				mem_we = 1'b1;
				if (rem_q == etr_pkg::REC_CNT_W'(1)) begin
					state_d = etr_pkg::ST_FIN;
				end
			end
			etr_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = etr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = etr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= etr_pkg::ST_IDLE;
			compact_q   <= 1'b1;
			fill_q      <= '0;
			last_time_q <= '0;
			active_q    <= 1'b0;
			blk_q       <= '0;
			rem_q       <= '0;
			res_acc_q   <= 1'b0;
			res_rv_q    <= 1'b0;
			res_blk_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				compact_q <= cfg_wr_data;
			end

			if (take) begin
				case (etr_pkg::op_t'(mode))
					etr_pkg::OP_START: begin
						fill_q      <= '0;
						last_time_q <= timestamp;
						active_q    <= 1'b1;
						blk_q       <= '0;
						res_acc_q   <= 1'b0;
						res_rv_q    <= 1'b0;
						res_blk_q   <= '0;
					end
					etr_pkg::OP_STOP: begin
						active_q  <= 1'b0;
						res_acc_q <= 1'b0;
						res_rv_q  <= 1'b0;
						res_blk_q <= blk_q;
					end
					etr_pkg::OP_CLEAR: begin
						if (active_q) begin
							fill_q <= '0;
						end
						res_acc_q <= 1'b0;
						res_rv_q  <= 1'b0;
						res_blk_q <= blk_q;
					end
					etr_pkg::OP_EVENT: begin
						res_acc_q <= ev_ok;
						res_rv_q  <= 1'b0;
						res_blk_q <= blk_q;
						if (ev_ok) begin
							rem_q <= rec.nbytes;
							if (compact_q) begin
								last_time_q <= timestamp;
							end
						end
					end
					etr_pkg::OP_DATA: begin
						res_acc_q <= db_ok;
						res_rv_q  <= 1'b0;
						if (db_ok) begin
							fill_q    <= fill_q + CW'(1);
							res_blk_q <= blk_q + etr_pkg::BLK_W'(1);
							blk_q     <= last_of_block ? '0 : blk_q + etr_pkg::BLK_W'(1);
						end else begin
							res_blk_q <= blk_q;
							if (last_of_block) begin
								blk_q <= '0;
							end
						end
					end
					etr_pkg::OP_READ: begin
						res_acc_q <= 1'b0;
						res_rv_q  <= rd_ok;
						res_blk_q <= blk_q;
					end
					default: begin
						res_acc_q <= 1'b0;
						res_rv_q  <= 1'b0;
						res_blk_q <= blk_q;
					end
				endcase
			end

			// advance through the record, one byte per cycle
			if (state_q == etr_pkg::ST_REC) begin
				fill_q <= fill_q + CW'(1);
				rem_q  <= rem_q - etr_pkg::REC_CNT_W'(1);
			end

			if (state_q == etr_pkg::ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && etr_pkg::op_t'(mode) == etr_pkg::OP_EVENT) begin
			rec_q <= rec.bytes;
		end else if (state_q == etr_pkg::ST_REC) begin
			rec_q <= rec_q >> 8;
		end
	end

	// hold the result until the output register is free
	always_ff @(posedge clk) begin
		if (state_q == etr_pkg::ST_FIN && out_free) begin
			accepted      <= res_acc_q;
			read_valid    <= res_rv_q;
			read_data     <= res_rv_q ? mem_rd_q : 8'd0;
			byte_count    <= fill_q;
			recording     <= active_q;
			block_written <= res_blk_q;
		end
	end

	assign out_valid = out_valid_q;

	`ETR_ASSERT_NOW(a_store_write_in_range, mem_we, fill_q < FULL, "store write beyond capacity")
	`ETR_ASSERT_NOW(a_rec_bytes_left, state_q == etr_pkg::ST_REC, rem_q != '0, "record with no bytes left")
	`ETR_ASSERT_NOW(a_result_from_fin, $rose(out_valid_q), $past(state_q) == etr_pkg::ST_FIN, "result without completion")

endmodule

>>> test/tb.sv
module tb;

	localparam int STORE_SIZE   = etr_pkg::STORE_BYTES_DEF;
	localparam int EVENT_ROOM   = etr_pkg::STORE_BYTES_DEF - etr_pkg::RECORD_RESERVE_DEF;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES  = 300;

	localparam logic [2:0] MODE_RSVD6 = 3'd6;
	localparam logic [2:0] MODE_RSVD7 = 3'd7;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] ts;
		logic [7:0]  label;
		logic [5:0]  code;
		logic [7:0]  dbyte;
		logic        last;
		logic [9:0]  addr;
	} trace_op_t;

	typedef struct packed {
		logic        accepted;
		logic [7:0]  rdata;
		logic        rvalid;
		logic [10:0] count;
		logic        rec;
		logic [10:0] blk;
	} trace_result_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_wr_en     = 1'b0;
	logic        cfg_wr_data   = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_stall;
	logic [2:0]  mode          = '0;
	logic [31:0] timestamp     = '0;
	logic [7:0]  label         = '0;
	logic [5:0]  event_code    = '0;
	logic [7:0]  data_byte     = '0;
	logic        last_of_block = 1'b0;
	logic [9:0]  read_address  = '0;
	logic        out_valid;
	logic        out_stall     = 1'b0;
	logic        accepted;
	logic [7:0]  read_data;
	logic        read_valid;
	logic [10:0] byte_count;
	logic        recording;
	logic [10:0] block_written;

	event_trace_recorder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.timestamp     (timestamp),
		.label         (label),
		.event_code    (event_code),
		.data_byte     (data_byte),
		.last_of_block (last_of_block),
		.read_address  (read_address),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.accepted      (accepted),
		.read_data     (read_data),
		.read_valid    (read_valid),
		.byte_count    (byte_count),
		.recording     (recording),
		.block_written (block_written)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Trace buffer shadow state
	logic [7:0]  trace_mem [STORE_SIZE];
	int          fill_cnt    = 0;
	logic [31:0] last_time   = '0;
	logic        rec_on      = 1'b0;
	int          blk_cnt     = 0;
	logic        compact_on  = 1'b1;

	trace_op_t     pending_ops [$];
	trace_result_t result_q [$];
	trace_op_t     cur_op;
	logic          op_taken  = 1'b0;
	logic          hold_req  = 1'b0;
	logic [31:0]   gen_ts    = '0;
	int            err_cnt   = 0;
	int            cycle_cnt = 0;

	function automatic void store_byte(logic [7:0] b);
		if (fill_cnt < STORE_SIZE) begin
			trace_mem[fill_cnt] = b;
			fill_cnt++;
		end
	endfunction

	function automatic logic log_event(logic [31:0] now, logic [7:0] lbl, logic [5:0] code);
		logic [31:0] delta;
		int          len;
		if (!rec_on || fill_cnt >= EVENT_ROOM)
			return 1'b0;
		store_byte(lbl);
		if (compact_on) begin
			delta = now - last_time;
			last_time = now;
			len = (delta < 32'h100) ? 0 : (delta < 32'h1_0000) ? 1 :
				(delta < 32'h100_0000) ? 2 : 3;
			store_byte({len[1:0], code});
			for (int i = 0; i <= len; i++)
				store_byte(delta[8*i +: 8]);
		end else begin
			store_byte({2'b00, code});
			for (int i = 0; i < 4; i++)
				store_byte(now[8*i +: 8]);
		end
		return 1'b1;
	endfunction

	function automatic trace_result_t apply_op(trace_op_t op);
		trace_result_t r;
		r = '0;
		case (op.mode)
			etr_pkg::OP_START: begin
				fill_cnt = 0;
				last_time = op.ts;
				rec_on = 1'b1;
				blk_cnt = 0;
			end
			etr_pkg::OP_STOP: rec_on = 1'b0;
			etr_pkg::OP_CLEAR: begin
				if (rec_on)
					fill_cnt = 0;
			end
			etr_pkg::OP_EVENT: r.accepted = log_event(op.ts, op.label, op.code);
			etr_pkg::OP_DATA: begin
				if (rec_on && fill_cnt < STORE_SIZE) begin
					store_byte(op.dbyte);
					blk_cnt++;
					r.accepted = 1'b1;
				end
			end
			etr_pkg::OP_READ: begin
				if (op.addr < fill_cnt) begin
					r.rvalid = 1'b1;
					r.rdata = trace_mem[op.addr];
				end
			end
			default: ;
		endcase
		r.count = 11'(fill_cnt);
		r.rec = rec_on;
		r.blk = 11'(blk_cnt);
		// block count shown includes this byte, then drop it at block end
		if (op.mode == etr_pkg::OP_DATA && op.last)
			blk_cnt = 0;
		return r;
	endfunction

	task automatic report_error(string msg);
		$display("ERROR at %0t: %s", $time, msg);
		err_cnt++;
	endtask

	// Acceptance capture and result checking
	always @(posedge clk) begin : monitor
		trace_result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				result_q.push_back(apply_op(cur_op));
				op_taken = 1'b1;
			end
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					report_error("result transaction with nothing outstanding");
				end else begin
					want = result_q.pop_front();
					if (accepted !== want.accepted)
						report_error($sformatf("accepted %b, want %b", accepted, want.accepted));
					if (read_data !== want.rdata)
						report_error($sformatf("read_data %h, want %h", read_data, want.rdata));
					if (read_valid !== want.rvalid)
						report_error($sformatf("read_valid %b, want %b", read_valid, want.rvalid));
					if (byte_count !== want.count)
						report_error($sformatf("byte_count %0d, want %0d", byte_count, want.count));
					if (recording !== want.rec)
						report_error($sformatf("recording %b, want %b", recording, want.rec));
					if (block_written !== want.blk)
						report_error($sformatf("block_written %0d, want %0d",
							block_written, want.blk));
				end
			end
		end
	end

	// Sender: bursts of transactions separated by random gaps
	int burst_cnt = 0;
	int gap_cnt   = 0;

	always @(negedge clk) begin : driver
		trace_op_t nxt;
		if (arst_n && (!in_valid || op_taken)) begin
			op_taken = 1'b0;
			if (gap_cnt != 0) begin
				gap_cnt--;
				in_valid <= 1'b0;
			end else if (pending_ops.size() != 0) begin
				nxt = pending_ops.pop_front();
				cur_op = nxt;
				mode <= nxt.mode;
				timestamp <= nxt.ts;
				label <= nxt.label;
				event_code <= nxt.code;
				data_byte <= nxt.dbyte;
				last_of_block <= nxt.last;
				read_address <= nxt.addr;
				in_valid <= 1'b1;
				if (burst_cnt == 0) begin
					burst_cnt = $urandom_range(1, 40);
					gap_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_cnt--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall pattern changes at random intervals, plus one long hold
	int hold_cnt    = 0;
	int stall_style = 0;
	int style_cnt   = 0;

	always @(negedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			if (style_cnt == 0) begin
				stall_style = $urandom_range(0, 3);
				style_cnt = $urandom_range(16, 96);
			end
			style_cnt--;
			case (stall_style)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (style_cnt % 3 == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic trace_op_t rand_op(logic [2:0] m);
		trace_op_t o;
		o.mode = m;
		o.ts = $urandom;
		o.label = 8'($urandom);
		o.code = 6'($urandom);
		o.dbyte = 8'($urandom);
		o.last = 1'($urandom);
		o.addr = 10'($urandom);
		return o;
	endfunction

	function automatic logic [31:0] rand_delta();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 32'hFF);
			1: return $urandom_range(32'h100, 32'hFFFF);
			2: return $urandom_range(32'h1_0000, 32'hFF_FFFF);
			default: return $urandom_range(32'h100_0000, 32'hFFFF_FFFF);
		endcase
	endfunction

	task automatic push_start(logic [31:0] t);
		trace_op_t o;
		o = rand_op(etr_pkg::OP_START);
		o.ts = t;
		gen_ts = t;
		pending_ops.push_back(o);
	endtask

	task automatic push_event(logic [31:0] delta, logic [7:0] lbl, logic [5:0] code);
		trace_op_t o;
		o = rand_op(etr_pkg::OP_EVENT);
		gen_ts = gen_ts + delta;
		o.ts = gen_ts;
		o.label = lbl;
		o.code = code;
		pending_ops.push_back(o);
	endtask

	task automatic push_data(logic [7:0] b, logic l);
		trace_op_t o;
		o = rand_op(etr_pkg::OP_DATA);
		o.dbyte = b;
		o.last = l;
		pending_ops.push_back(o);
	endtask

	task automatic push_read(logic [9:0] a);
		trace_op_t o;
		o = rand_op(etr_pkg::OP_READ);
		o.addr = a;
		pending_ops.push_back(o);
	endtask

	task automatic push_plain(logic [2:0] m);
		pending_ops.push_back(rand_op(m));
	endtask

	// Mostly recording sessions: start, events, data blocks and reads; some noise
	task automatic push_random(int n);
		int k;
		int r;
		int len;
		k = 0;
		while (k < n) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				push_start($urandom);
				k++;
			end else if (r < 4) begin
				push_plain(etr_pkg::OP_STOP);
				k++;
			end else if (r < 6) begin
				push_plain(etr_pkg::OP_CLEAR);
				k++;
			end else if (r < 8) begin
				push_plain($urandom_range(0, 1) ? MODE_RSVD7 : MODE_RSVD6);
				k++;
			end else if (r < 50) begin
				if ($urandom_range(0, 15) == 0)
					gen_ts = $urandom;
				push_event(rand_delta(), 8'($urandom), 6'($urandom));
				k++;
			end else if (r < 78) begin
				len = $urandom_range(1, 8);
				for (int j = 0; j < len; j++)
					push_data(8'($urandom), j == len - 1);
				k += len;
			end else begin
				push_read(10'($urandom));
				k++;
			end
		end
	endtask

	task automatic wait_idle();
		while (pending_ops.size() != 0 || in_valid || result_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_compact(logic v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		compact_on = v;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: refusals while stopped, delta length boundaries, blocks, reads
		push_plain(etr_pkg::OP_EVENT);
		push_data(8'h5A, 1'b1);
		push_plain(etr_pkg::OP_CLEAR);
		push_plain(MODE_RSVD6);
		push_plain(MODE_RSVD7);
		push_start(32'hFFFF_FF00);
		push_event(32'h0, 8'hFF, 6'h3F);
		push_event(32'hFF, 8'h00, 6'h00);
		push_event(32'h100, 8'h81, 6'h21);
		push_event(32'hFFFF, 8'h7E, 6'h1E);
		push_event(32'h1_0000, 8'h01, 6'h01);
		push_event(32'hFF_FFFF, 8'hC3, 6'h2A);
		push_event(32'h100_0000, 8'h3C, 6'h15);
		push_event(32'hFFFF_FFFF, 8'hFE, 6'h3E);
		push_data(8'h00, 1'b0);
		push_data(8'hFF, 1'b0);
		push_data(8'hA5, 1'b1);
		push_read(10'd0);
		push_plain(etr_pkg::OP_STOP);
		push_read(10'd1);
		push_plain(etr_pkg::OP_EVENT);
		push_data(8'h33, 1'b0);
		push_plain(etr_pkg::OP_CLEAR);
		push_read(10'd2);
		push_start(32'h0);
		push_data(8'h96, 1'b0);
		push_plain(etr_pkg::OP_CLEAR);
		push_read(10'd1);
		wait_idle();

		// Full-timestamp records until events are refused, then fill the last bytes
		write_compact(1'b0);
		push_start($urandom);
		repeat (175)
			push_event(rand_delta(), 8'($urandom), 6'($urandom));
		for (int j = 0; j < 8; j++)
			push_data(8'($urandom), j == 7);
		push_read(10'h3FF);
		push_read(10'h3FE);
		push_read(10'h200);
		push_read(10'h000);
		push_plain(etr_pkg::OP_STOP);
		push_read(10'h3FF);
		push_data(8'h11, 1'b1);
		wait_idle();

		write_compact(1'b1);
		push_random(800);
		hold_req = 1'b1;
		wait_idle();

		write_compact(1'b0);
		push_random(500);
		wait_idle();

		write_compact(1'b1);
		push_random(380);
		wait_idle();

		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/etr_pkg.sv
hdl/etr_rec_fmt.sv
hdl/event_trace_recorder.sv
test/tb.sv
